FILE: sv/lpcc_pkg.sv
package lpcc_pkg;

   // Field widths of the transactions.
   localparam int KEY_W  = 20;
   localparam int LOC_W  = 32;
   localparam int SIZE_W = 16;
   localparam int CAP_W  = 5;
   localparam int CNT_W  = 32;

   // Default number of cells in the recency row.
   localparam int CAPACITY_DEFAULT = 16;

   // Capacity register value after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Saturation value of the allocator and of the counters.
   localparam logic [LOC_W-1:0] WORD_MAX = {LOC_W{1'b1}};

   // Command codes.
   typedef enum logic [0:0] {
      CMD_ADD    = 1'b0,
      CMD_ACCESS = 1'b1
   } cmd_type;

   // One resident element as it sits in a cell.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [LOC_W-1:0]  location;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // Controls broadcast from the controller to every cell.
   typedef struct packed {
      logic             shift_all;   // every cell with a resident right neighbor takes it
      logic             shift_match; // cells at or past the matching one shift
      logic             load_last;   // the most recently used cell takes mru
      logic             load_free;   // the first free cell takes mru
      logic [KEY_W-1:0] lookup_key;
      entry_type        mru;
   } cell_ctrl_type;

   // Request transaction.
   typedef struct packed {
      cmd_type           command;
      logic [KEY_W-1:0]  element_id;
      logic [LOC_W-1:0]  element_location;
      logic [SIZE_W-1:0] element_size;
   } req_payload_type;

   // Response transaction.
   typedef struct packed {
      logic              hit;
      logic              load_needed;
      logic [LOC_W-1:0]  assigned_location;
      logic              evict_valid;
      logic [KEY_W-1:0]  evict_id;
      logic [LOC_W-1:0]  evict_location;
      logic [SIZE_W-1:0] evict_size;
      logic [CNT_W-1:0]  hit_count;
      logic [CNT_W-1:0]  try_count;
      logic              location_overflow;
   } rsp_payload_type;

endpackage

FILE: sv/lpcc_cell.sv
// One position of the recency row. Cell 0 is least recently used; resident
// cells form a contiguous run from cell 0 upward.
module lpcc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lpcc_pkg::cell_ctrl_type ctrl,
   input  lpcc_pkg::entry_type   right_entry,
   input  logic                  right_valid,
   input  logic                  left_valid,
   input  logic                  seen_in,
   output lpcc_pkg::entry_type   entry,
   output logic                  valid,
   output logic                  match,
   output logic                  seen_out,
   output lpcc_pkg::entry_type   match_entry
);

   lpcc_pkg::entry_type entry_ff;
   lpcc_pkg::entry_type entry_in;
   logic                valid_ff;
   logic                valid_in;
   logic                shift;
   logic                load;

   // Key compare and the running "match at or below me" chain.
   assign match       = valid_ff && (entry_ff.key == ctrl.lookup_key);
   assign seen_out    = seen_in | match;
   assign match_entry = match ? entry_ff : '0;

   // A cell shifts only while its right neighbor is resident. It loads either
   // as the top resident cell or as the lowest free cell.
   always_comb begin
      shift = right_valid && (ctrl.shift_all || (ctrl.shift_match && seen_out));
      load  = (ctrl.load_last && valid_ff && !right_valid) ||
              (ctrl.load_free && !valid_ff && left_valid);
      priority if (load) begin
         entry_in = ctrl.mru;
      end else if (shift) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
      valid_in = valid_ff | load;
   end

   // Residency bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry contents.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

FILE: sv/lru_paging_cache_controller_top.sv
// LRU paging cache controller. Takes one add or access command per clock
// cycle while req_stall is low and returns one response per command from a
// response register, in the cycle after acceptance. The row of CAPACITY
// cells compares every resident key in parallel and shifts the recency order by
// one position in the same cycle. Cell 0 holds the least recently used entry. The
// capacity register may be written only while no transaction is in flight;
// values above CAPACITY act as CAPACITY and zero disables caching. There is
// no clearing pass after reset: the block accepts commands at once.
module lru_paging_cache_controller_top #(
   parameter int CAPACITY = lpcc_pkg::CAPACITY_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lpcc_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lpcc_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lpcc_pkg::CAP_W-1:0] csr_data
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > lpcc_pkg::CAP_W) ? CW : lpcc_pkg::CAP_W;

   logic [lpcc_pkg::CAP_W-1:0] capacity_ff;
   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic [lpcc_pkg::LOC_W-1:0] next_loc_ff;
   logic [lpcc_pkg::LOC_W-1:0] next_loc_in;
   logic [lpcc_pkg::CNT_W-1:0] hits_ff;
   logic [lpcc_pkg::CNT_W-1:0] hits_in;
   logic [lpcc_pkg::CNT_W-1:0] tries_ff;
   logic [lpcc_pkg::CNT_W-1:0] tries_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   lpcc_pkg::rsp_payload_type  rsp_payload_ff;
   lpcc_pkg::rsp_payload_type  rsp_payload_in;

   lpcc_pkg::cell_ctrl_type    ctrl;
   lpcc_pkg::entry_type        cell_entry [CAPACITY];
   lpcc_pkg::entry_type        cell_match_entry [CAPACITY];
   logic [CAPACITY-1:0]        cell_valid;
   logic [CAPACITY-1:0]        cell_match;
   logic [CAPACITY:0]          seen_chain;

   lpcc_pkg::entry_type        found_entry;
   lpcc_pkg::entry_type        new_entry;
   logic                       accept;
   logic                       found;
   logic                       is_add;
   logic                       lookup_on;
   logic                       at_limit;
   logic [CMPW-1:0]            eff_cap;
   logic [lpcc_pkg::LOC_W:0]   loc_sum;

   // Handshakes: the response register frees up when it is empty or taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

   // The row of cells, chained through valid bits and the match prefix.
   assign seen_chain[0] = 1'b0;
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lpcc_pkg::entry_type right_entry;
      logic                right_valid;
      logic                left_valid;
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end
      if (i == 0) begin : g_first
         assign left_valid = 1'b1;
      end else begin : g_rest
         assign left_valid = cell_valid[i-1];
      end
      lpcc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .left_valid  (left_valid),
         .seen_in     (seen_chain[i]),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .match       (cell_match[i]),
         .seen_out    (seen_chain[i+1]),
         .match_entry (cell_match_entry[i])
      );
   end

   // Gather the matching entry; resident keys are unique.
   always_comb begin
      found_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found_entry = lpcc_pkg::entry_type'(found_entry | cell_match_entry[i]);
      end
      found = |cell_match;
   end

   // Command decode, allocator, counters and cell controls.
   always_comb begin
      is_add    = req_payload.command == lpcc_pkg::CMD_ADD;
      lookup_on = is_add || (capacity_ff != '0);
      eff_cap   = (CMPW'(capacity_ff) > CMPW'(CAPACITY)) ? CMPW'(CAPACITY)
                                                         : CMPW'(capacity_ff);
      at_limit  = CMPW'(count_ff) >= eff_cap;
      loc_sum   = {1'b0, next_loc_ff} +
                  (lpcc_pkg::LOC_W + 1)'(req_payload.element_size);

      new_entry.key      = req_payload.element_id;
      new_entry.location = is_add ? next_loc_ff : req_payload.element_location;
      new_entry.size     = req_payload.element_size;

      ctrl            = '0;
      ctrl.lookup_key = req_payload.element_id;
      count_in        = count_ff;
      next_loc_in     = next_loc_ff;
      hits_in         = hits_ff;
      tries_in        = tries_ff;
      rsp_payload_in  = '0;

      if (accept) begin
         // Allocation on add, try counting on access.
         if (is_add) begin
            next_loc_in = loc_sum[lpcc_pkg::LOC_W] ? lpcc_pkg::WORD_MAX
                                                   : loc_sum[lpcc_pkg::LOC_W-1:0];
            rsp_payload_in.assigned_location = next_loc_ff;
         end else if (tries_ff != lpcc_pkg::WORD_MAX) begin
            tries_in = tries_ff + 1'b1;
         end

         priority if (lookup_on && found) begin
            // Resident: move to most recently used, refreshing on add.
            ctrl.shift_match = 1'b1;
            ctrl.load_last   = 1'b1;
            ctrl.mru         = found_entry;
            if (is_add) begin
               ctrl.mru.location = next_loc_ff;
               ctrl.mru.size     = req_payload.element_size;
            end else begin
               rsp_payload_in.hit = 1'b1;
               if (hits_ff != lpcc_pkg::WORD_MAX) begin
                  hits_in = hits_ff + 1'b1;
               end
            end
         end else if (lookup_on) begin
            // Not resident: insert, evicting one entry when full.
            rsp_payload_in.load_needed = !is_add;
            ctrl.mru = new_entry;
            if (at_limit) begin
               rsp_payload_in.evict_valid = 1'b1;
               if (count_ff == '0) begin
                  rsp_payload_in.evict_id       = new_entry.key;
                  rsp_payload_in.evict_location = new_entry.location;
                  rsp_payload_in.evict_size     = new_entry.size;
               end else begin
                  rsp_payload_in.evict_id       = cell_entry[0].key;
                  rsp_payload_in.evict_location = cell_entry[0].location;
                  rsp_payload_in.evict_size     = cell_entry[0].size;
                  ctrl.shift_all = 1'b1;
                  ctrl.load_last = 1'b1;
               end
            end else begin
               ctrl.load_free = 1'b1;
               count_in       = count_ff + 1'b1;
            end
         end else begin
            // Caching disabled: an access only asks for a load.
            rsp_payload_in.load_needed = 1'b1;
         end
      end

      rsp_payload_in.hit_count         = hits_in;
      rsp_payload_in.try_count         = tries_in;
      rsp_payload_in.location_overflow = next_loc_in == lpcc_pkg::WORD_MAX;

      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lpcc_pkg::CAP_RESET;
         count_ff     <= '0;
         next_loc_ff  <= '0;
         hits_ff      <= '0;
         tries_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         count_ff     <= count_in;
         next_loc_ff  <= next_loc_in;
         hits_ff      <= hits_in;
         tries_ff     <= tries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // Occupancy never exceeds the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CAPACITY)
      else $error("resident count beyond cell count");

   // Residency bits agree with the occupancy counter.
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("cell valid bits disagree with resident count");

   // At most one cell matches a lookup key.
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_match))
      else $error("duplicate resident key");

   // Occupancy only grows.
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("resident count dropped");

   // A hit neither loads nor evicts.
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.hit |->
         !rsp_payload_ff.load_needed && !rsp_payload_ff.evict_valid)
      else $error("hit response with load or eviction");

endmodule
